/* sv/bmpfb_pkg.sv */
// Shared constants and register indexes for the BMP stream decimator.
package bmpfb_pkg;

    localparam int MAX_DIM      = 1024;
    localparam int HDR_LEN      = 54;
    localparam int W_OFF        = 18;
    localparam int H_OFF        = 22;
    localparam int BYTE_W       = 8;
    localparam int HC_W         = 6;
    localparam int DIM_LO_W     = 16;
    localparam int OFFSET_W     = 10;
    localparam int LINE_W       = 11;
    localparam int ADDR_W       = 20;
    localparam int PIXEL_W      = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 11'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_OFFSET = 2'd0,
        REG_COL_OFFSET = 2'd1,
        REG_LINE_WIDTH = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2
    } byte_phase_t;

endpackage

/* sv/bmp_stream_to_framebuffer_decimator.sv */
// Top level: BMP byte stream parser that emits decimated framebuffer writes.
//
// Usage: feed a 24-bit BMP file one byte per request on the input channel
// (file_byte, first_byte); first_byte marks byte zero of a file and restarts
// parsing. Each red byte of a pixel whose display row plus column is even
// yields one request on the output channel (fb_address, pixel_word).
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
// Throughput: one byte per cycle while the output is not stalled; the parser
// state, the 11x11 address multiplier and the output register all update in
// the single stage after the input register.
// Stall: while the output register holds a stalled result, the input register
// holds its byte and in_stall rises; no request is lost or repeated.
// Reset: rst_n clears all parse state and both valid flags; the row and
// column offsets return to 0 and line_width to 640. Configuration (row offset,
// column offset, line_width) is written through cfg_write/cfg_index/cfg_data.
module bmp_stream_to_framebuffer_decimator #(
    parameter int MAX_DIM = bmpfb_pkg::MAX_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bmpfb_pkg::BYTE_W-1:0]        file_byte,
    input  logic                                first_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bmpfb_pkg::ADDR_W-1:0]        fb_address,
    output logic [bmpfb_pkg::PIXEL_W-1:0]       pixel_word,
    input  logic                                cfg_write,
    input  logic [bmpfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmpfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int I_W    = ((DIM_W > bmpfb_pkg::OFFSET_W) ? DIM_W : bmpfb_pkg::OFFSET_W) + 1;
    localparam int PROD_W = I_W - 1 + bmpfb_pkg::LINE_W;
    localparam int DLO_W  = bmpfb_pkg::DIM_LO_W;
    localparam int HC_W   = bmpfb_pkg::HC_W;
    localparam int BW     = bmpfb_pkg::BYTE_W;

    // configuration
    logic [bmpfb_pkg::OFFSET_W-1:0] row_offset_reg, col_offset_reg;
    logic [bmpfb_pkg::LINE_W-1:0]   line_width_reg;

    // input register
    logic          in_valid_reg;
    logic [BW-1:0] byte_reg;
    logic          first_reg;

    // parser state
    logic [HC_W-1:0]  header_count_reg, header_count_next;
    logic [DLO_W-1:0] image_width_reg, image_width_next;
    logic [DLO_W-1:0] image_height_reg, image_height_next;
    logic             width_hi_reg, width_hi_next;
    logic             height_hi_reg, height_hi_next;
    logic [DIM_W-1:0] row_left_reg, row_left_next;
    logic [DIM_W-1:0] pixel_col_reg, pixel_col_next;
    bmpfb_pkg::byte_phase_t byte_phase_reg, byte_phase_next;
    logic [1:0]       pad_left_reg, pad_left_next;
    logic [BW-1:0]    held_blue_reg, held_blue_next;
    logic [BW-1:0]    held_green_reg, held_green_next;
    logic             image_done_reg, image_done_next;

    // output register
    logic                          out_valid_reg;
    logic [bmpfb_pkg::ADDR_W-1:0]  fb_address_reg, fb_address_next;
    logic [bmpfb_pkg::PIXEL_W-1:0] pixel_word_reg, pixel_word_next;

    logic advance, process, emit;
    logic [I_W-1:0]    disp_row, disp_col;
    logic [PROD_W-1:0] row_base;
    logic              width_ok, height_ok;

    assign advance   = !(out_valid_reg && out_stall);
    assign process   = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign fb_address = fb_address_reg;
    assign pixel_word = pixel_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_offset_reg <= '0;
            col_offset_reg <= '0;
            line_width_reg <= bmpfb_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bmpfb_pkg::REG_ROW_OFFSET: row_offset_reg <= cfg_data[bmpfb_pkg::OFFSET_W-1:0];
                bmpfb_pkg::REG_COL_OFFSET: col_offset_reg <= cfg_data[bmpfb_pkg::OFFSET_W-1:0];
                bmpfb_pkg::REG_LINE_WIDTH: line_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            byte_reg  <= file_byte;
            first_reg <= first_byte;
        end
    end

    // display position and address of the current pixel
    assign disp_row = I_W'(row_offset_reg) + I_W'(row_left_reg);
    assign disp_col = I_W'(col_offset_reg) + I_W'(pixel_col_reg);
    assign row_base = PROD_W'(disp_row[I_W-1:1]) * PROD_W'(line_width_reg);

    always_comb
    begin
        logic [HC_W-1:0]  hc;
        logic [DLO_W-1:0] w_lo, h_lo;
        logic             w_hi, h_hi, done;
        logic [DIM_W-1:0] rows, col;
        bmpfb_pkg::byte_phase_t ph;
        logic [1:0]       pad;
        logic [BW-1:0]    hb, hg;
        logic             next_row;

        // restart on first byte, else carry the stored state
        hc   = first_reg ? '0 : header_count_reg;
        w_lo = first_reg ? '0 : image_width_reg;
        h_lo = first_reg ? '0 : image_height_reg;
        w_hi = first_reg ? 1'b0 : width_hi_reg;
        h_hi = first_reg ? 1'b0 : height_hi_reg;
        done = first_reg ? 1'b0 : image_done_reg;
        rows = first_reg ? '0 : row_left_reg;
        col  = first_reg ? '0 : pixel_col_reg;
        ph   = first_reg ? bmpfb_pkg::PH_BLUE : byte_phase_reg;
        pad  = first_reg ? '0 : pad_left_reg;
        hb   = first_reg ? '0 : held_blue_reg;
        hg   = first_reg ? '0 : held_green_reg;

        next_row = 1'b0;
        emit     = 1'b0;
        width_ok  = !w_hi && (w_lo != '0) && (w_lo <= DLO_W'(MAX_DIM));
        height_ok = !h_hi && (h_lo != '0) && (h_lo <= DLO_W'(MAX_DIM));

        if (hc < HC_W'(bmpfb_pkg::HDR_LEN))
        begin
            priority if (hc == HC_W'(bmpfb_pkg::W_OFF))
                w_lo[7:0] = byte_reg;
            else if (hc == HC_W'(bmpfb_pkg::W_OFF + 1))
                w_lo[15:8] = byte_reg;
            else if (hc == HC_W'(bmpfb_pkg::W_OFF + 2) || hc == HC_W'(bmpfb_pkg::W_OFF + 3))
                w_hi = w_hi || (byte_reg != '0);
            else if (hc == HC_W'(bmpfb_pkg::H_OFF))
                h_lo[7:0] = byte_reg;
            else if (hc == HC_W'(bmpfb_pkg::H_OFF + 1))
                h_lo[15:8] = byte_reg;
            else if (hc == HC_W'(bmpfb_pkg::H_OFF + 2) || hc == HC_W'(bmpfb_pkg::H_OFF + 3))
                h_hi = h_hi || (byte_reg != '0);
            else if (hc == HC_W'(bmpfb_pkg::HDR_LEN - 1))
            begin
                // size fields are complete here; reject bad sizes
                if (width_ok && height_ok)
                    rows = DIM_W'(h_lo - DLO_W'(1));
                else
                    done = 1'b1;
            end
            hc = hc + HC_W'(1);
        end
        else if (!done)
        begin
            if (pad != '0)
            begin
                pad = pad - 2'd1;
                if (pad == '0)
                    next_row = 1'b1;
            end
            else
            begin
                unique case (ph)
                    bmpfb_pkg::PH_BLUE:
                    begin
                        hb = byte_reg;
                        ph = bmpfb_pkg::PH_GREEN;
                    end
                    bmpfb_pkg::PH_GREEN:
                    begin
                        hg = byte_reg;
                        ph = bmpfb_pkg::PH_RED;
                    end
                    default:
                    begin
                        ph   = bmpfb_pkg::PH_BLUE;
                        emit = (disp_row[0] == disp_col[0]);
                        if (col + DIM_W'(1) == w_lo[DIM_W-1:0])
                        begin
                            // row padding equals width mod 4 for 3-byte pixels
                            pad = w_lo[1:0];
                            if (pad == '0)
                                next_row = 1'b1;
                        end
                        else
                            col = col + DIM_W'(1);
                    end
                endcase
            end
            if (next_row)
            begin
                col = '0;
                if (rows == '0)
                    done = 1'b1;
                else
                    rows = rows - DIM_W'(1);
            end
        end

        header_count_next = hc;
        image_width_next  = w_lo;
        image_height_next = h_lo;
        width_hi_next     = w_hi;
        height_hi_next    = h_hi;
        image_done_next   = done;
        row_left_next     = rows;
        pixel_col_next    = col;
        byte_phase_next   = ph;
        pad_left_next     = pad;
        held_blue_next    = hb;
        held_green_next   = hg;

        fb_address_next = row_base[bmpfb_pkg::ADDR_W-1:0]
                        + bmpfb_pkg::ADDR_W'(disp_col[I_W-1:1]);
        pixel_word_next = {held_blue_reg, held_green_reg, byte_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            width_hi_reg     <= 1'b0;
            height_hi_reg    <= 1'b0;
            image_done_reg   <= 1'b0;
            row_left_reg     <= '0;
            pixel_col_reg    <= '0;
            byte_phase_reg   <= bmpfb_pkg::PH_BLUE;
            pad_left_reg     <= '0;
            held_blue_reg    <= '0;
            held_green_reg   <= '0;
        end
        else if (process)
        begin
            header_count_reg <= header_count_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            width_hi_reg     <= width_hi_next;
            height_hi_reg    <= height_hi_next;
            image_done_reg   <= image_done_next;
            row_left_reg     <= row_left_next;
            pixel_col_reg    <= pixel_col_next;
            byte_phase_reg   <= byte_phase_next;
            pad_left_reg     <= pad_left_next;
            held_blue_reg    <= held_blue_next;
            held_green_reg   <= held_green_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= process && emit;
    end

    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            fb_address_reg <= fb_address_next;
            pixel_word_reg <= pixel_word_next;
        end
    end

endmodule

/* sv/bmpfb_checker.sv */
// Port-level checker for the BMP stream decimator, bound to the top level.
module bmpfb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [bmpfb_pkg::ADDR_W-1:0]     fb_address,
    input logic [bmpfb_pkg::PIXEL_W-1:0]    pixel_word
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fb_address) && $stable(pixel_word))
        else $error("stalled output request changed");

    // input stalls only behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a new result follows an accepted request through the input and output registers
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output request without matching input request");

endmodule

bind bmp_stream_to_framebuffer_decimator bmpfb_checker u_bmpfb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .fb_address (fb_address),
    .pixel_word (pixel_word)
);
